// ===== hdl/dnn_pkg.sv =====
`default_nettype none

package dnn_pkg;

    // Depth of the store that holds blanks whose fate is still open.
    localparam int MAX_PENDING_BLANKS = 16;
    localparam int CNT_W = $clog2(MAX_PENDING_BLANKS + 1);
    localparam int PTR_W = (MAX_PENDING_BLANKS > 1) ? $clog2(MAX_PENDING_BLANKS) : 1;

    // Command queue between the parser and the output sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;

    // One command per accepted input word. The back end emits, in order:
    // the oldest stored blank if the store overflows, the stored blanks if
    // flushed, up to two bytes, and an end marker if nothing else came out.
    typedef struct packed {
        logic       has_out;
        logic       ovf;
        logic       push;
        logic       kind;
        logic       clear;
        logic       flush;
        logic [1:0] nch;
        logic [7:0] ch0;
        logic [7:0] ch1;
        logic       marker;
        logic       fin;
    } t_cmd;

endpackage

`default_nettype wire

// ===== hdl/dnn_front.sv =====
`default_nettype none

module dnn_front
    import dnn_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_char,
    input  wire logic       i_final,
    input  wire logic       i_full,
    output logic            o_stall,
    output logic            o_wr_en,
    output t_cmd            o_cmd
);

    typedef enum logic [6:0] {
        ST_B4TYPE   = 7'b0000001,
        ST_INTYPE   = 7'b0000010,
        ST_B4EQUAL  = 7'b0000100,
        ST_B4VALUE  = 7'b0001000,
        ST_INVALUE  = 7'b0010000,
        ST_INQUOTED = 7'b0100000,
        ST_B4SEP    = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic               r_esc, n_esc;
    logic               r_held, n_held;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_cmd               cmd;
    logic               do_push;
    logic [CNT_W-1:0]   cnt_after;
    logic               blank, sep, needs;
    logic [7:0]         sep_out;

    assign blank   = (i_char == CH_SPACE) || (i_char == CH_NL);
    assign sep     = (i_char == CH_COMMA) || (i_char == CH_SEMI) || (i_char == CH_PLUS);
    assign needs   = (i_char == CH_BSLASH) || (i_char == CH_QUOTE);
    assign sep_out = (i_char == CH_PLUS) ? CH_PLUS : CH_COMMA;

    assign o_stall = i_full;
    assign o_wr_en = i_valid && !i_full;
    assign o_cmd   = cmd;

    always_comb begin
        cmd       = '0;
        cmd.kind  = (i_char == CH_NL);
        cmd.fin   = i_final;
        cmd.ch0   = i_char;
        n_state   = r_state;
        n_held    = r_held;
        n_cnt     = r_cnt;
        n_esc     = (i_char == CH_BSLASH) && !r_esc;
        do_push   = 1'b0;
        cnt_after = '0;

        unique case (r_state)
            ST_B4TYPE: begin
                if (!blank) begin
                    n_state = ST_INTYPE;
                    cmd.nch = 2'd1;
                end
            end
            ST_INTYPE: begin
                if (i_char == CH_EQUAL) begin
                    n_state = ST_B4VALUE;
                    cmd.nch = 2'd1;
                end else if (blank) begin
                    n_state = ST_B4EQUAL;
                end else begin
                    cmd.nch = 2'd1;
                end
            end
            ST_B4EQUAL: begin
                if (i_char == CH_EQUAL) begin
                    n_state = ST_B4VALUE;
                    cmd.nch = 2'd1;
                end else if (!blank) begin
                    cmd.nch = 2'd1;
                end
            end
            ST_B4VALUE: begin
                if (i_char == CH_QUOTE) begin
                    n_state = ST_INQUOTED;
                    cmd.nch = 2'd1;
                end else if (!blank) begin
                    n_state = ST_INVALUE;
                    if ((i_char == CH_BSLASH) && !r_esc) begin
                        n_held = 1'b1;
                    end else begin
                        cmd.nch = 2'd1;
                    end
                end
            end
            ST_INVALUE: begin
                if (!r_esc && sep) begin
                    cmd.clear = 1'b1;
                    n_cnt     = '0;
                    n_state   = ST_B4TYPE;
                    cmd.nch   = 2'd1;
                    cmd.ch0   = sep_out;
                end else if (r_esc && !needs && !sep) begin
                    n_held = 1'b0;
                    if (blank) begin
                        do_push = 1'b1;
                    end else begin
                        cmd.flush = 1'b1;
                        n_cnt     = '0;
                        cmd.nch   = 2'd1;
                    end
                end else if (r_esc) begin
                    n_held    = 1'b0;
                    cmd.flush = 1'b1;
                    n_cnt     = '0;
                    cmd.nch   = 2'd2;
                    cmd.ch0   = CH_BSLASH;
                    cmd.ch1   = i_char;
                end else if (i_char == CH_BSLASH) begin
                    n_held = 1'b1;
                end else if (blank) begin
                    do_push = 1'b1;
                end else begin
                    cmd.flush = 1'b1;
                    n_cnt     = '0;
                    cmd.nch   = 2'd1;
                end
            end
            ST_INQUOTED: begin
                if (!r_esc && (i_char == CH_QUOTE)) begin
                    n_state = ST_B4SEP;
                    cmd.nch = 2'd1;
                end else if (r_esc) begin
                    n_held = 1'b0;
                    if (needs) begin
                        cmd.nch = 2'd2;
                        cmd.ch0 = CH_BSLASH;
                        cmd.ch1 = i_char;
                    end else begin
                        cmd.nch = 2'd1;
                    end
                end else if (i_char == CH_BSLASH) begin
                    n_held = 1'b1;
                end else begin
                    cmd.nch = 2'd1;
                end
            end
            ST_B4SEP: begin
                if (sep) begin
                    n_state = ST_B4TYPE;
                    cmd.nch = 2'd1;
                    cmd.ch0 = sep_out;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase

        // A full store sends its oldest blank out early; the count holds.
        if (do_push) begin
            cmd.push = 1'b1;
            if (r_cnt == CNT_W'(MAX_PENDING_BLANKS)) begin
                cmd.ovf = 1'b1;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
        cnt_after = n_cnt;

        // End of name: waiting blanks go out, then a held backslash.
        if (i_final) begin
            cmd.flush = 1'b1;
            if (n_held) begin
                if (cmd.nch == 2'd0) begin
                    cmd.ch0 = CH_BSLASH;
                    cmd.nch = 2'd1;
                end else begin
                    cmd.ch1 = CH_BSLASH;
                    cmd.nch = 2'd2;
                end
            end
            cmd.marker = !cmd.ovf && (cnt_after == '0) && (cmd.nch == 2'd0);
            n_state = ST_B4TYPE;
            n_esc   = 1'b0;
            n_held  = 1'b0;
            n_cnt   = '0;
        end

        cmd.has_out = cmd.ovf || (cmd.nch != 2'd0) || cmd.marker
                      || (i_final && (cnt_after != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_B4TYPE;
            r_esc   <= 1'b0;
            r_held  <= 1'b0;
            r_cnt   <= '0;
        end else if (o_wr_en) begin
            r_state <= n_state;
            r_esc   <= n_esc;
            r_held  <= n_held;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dnn_queue.sv =====
`default_nettype none

module dnn_queue
    import dnn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr_en,
    input  wire t_cmd i_wr_cmd,
    output logic      o_full,
    input  wire logic i_rd_en,
    output t_cmd      o_rd_cmd,
    output logic      o_empty
);

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_rd_cmd = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_entry[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr_en && i_rd_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dnn_back.sv =====
`default_nettype none

module dnn_back
    import dnn_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  wire t_cmd       i_cmd,
    output logic            o_rd_en,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_char_valid,
    output logic            o_trim_overflow,
    output logic            o_name_done,
    output logic            o_last_of_run
);

    // Blank store: a ring of kind bits, 0 for space and 1 for newline.
    logic               r_kind_mem [MAX_PENDING_BLANKS];
    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_busy;
    logic               r_ovf, r_kind, r_flush, r_marker, r_fin;
    logic [1:0]         r_nch;
    logic [7:0]         r_ch0, r_ch1;

    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_char_valid, r_trim_overflow, r_name_done, r_last_of_run;

    logic               out_free, emit, last, load;
    logic               sel_ovf, sel_flush, sel_char;
    logic [7:0]         e_char;
    logic               e_char_valid;
    logic [CNT_W:0]     tail_sum;
    logic [PTR_W-1:0]   tail;
    logic [PTR_W-1:0]   head_inc;
    logic [7:0]         head_blank;
    logic               load_push;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = r_busy && out_free;
    assign head_blank = r_kind_mem[r_head] ? CH_NL : CH_SPACE;
    assign head_inc   = (r_head == PTR_W'(MAX_PENDING_BLANKS - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        tail_sum = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_cnt);
        if (tail_sum >= (CNT_W + 1)'(MAX_PENDING_BLANKS)) begin
            tail_sum = tail_sum - (CNT_W + 1)'(MAX_PENDING_BLANKS);
        end
        tail = tail_sum[PTR_W-1:0];
    end

    always_comb begin
        sel_ovf      = 1'b0;
        sel_flush    = 1'b0;
        sel_char     = 1'b0;
        e_char       = 8'h00;
        e_char_valid = 1'b1;
        last         = 1'b1;
        priority if (r_ovf) begin
            sel_ovf = 1'b1;
            e_char  = head_blank;
            last    = !r_flush && (r_nch == 2'd0) && !r_marker;
        end else if (r_flush && (r_cnt != '0)) begin
            sel_flush = 1'b1;
            e_char    = head_blank;
            last      = (r_cnt == CNT_W'(1)) && (r_nch == 2'd0) && !r_marker;
        end else if (r_nch != 2'd0) begin
            sel_char = 1'b1;
            e_char   = r_ch0;
            last     = (r_nch == 2'd1) && !r_marker;
        end else begin
            e_char_valid = 1'b0;
        end
    end

    assign load      = !i_empty && (!r_busy || (emit && last));
    assign o_rd_en   = load;
    assign load_push = load && i_cmd.push && !i_cmd.ovf;

    always_ff @(posedge i_clk) begin
        if (emit && sel_ovf) begin
            r_kind_mem[tail] <= r_kind;
        end else if (load_push) begin
            r_kind_mem[tail] <= i_cmd.kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else begin
            if (emit && (sel_ovf || sel_flush)) begin
                r_head <= head_inc;
            end
            if (load && i_cmd.clear) begin
                r_cnt <= '0;
            end else if (emit && sel_flush && !load_push) begin
                r_cnt <= r_cnt - 1'b1;
            end else if (load_push && !(emit && sel_flush)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= i_cmd.has_out;
        end else if (emit && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ovf    <= i_cmd.ovf;
            r_kind   <= i_cmd.kind;
            r_flush  <= i_cmd.flush;
            r_nch    <= i_cmd.nch;
            r_ch0    <= i_cmd.ch0;
            r_ch1    <= i_cmd.ch1;
            r_marker <= i_cmd.marker;
            r_fin    <= i_cmd.fin;
        end else if (emit) begin
            if (sel_ovf) begin
                r_ovf <= 1'b0;
            end
            if (sel_char) begin
                r_ch0 <= r_ch1;
                r_nch <= r_nch - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_char      <= e_char;
            r_char_valid    <= e_char_valid;
            r_trim_overflow <= sel_ovf;
            r_name_done     <= last && r_fin;
            r_last_of_run   <= last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_char_valid    = r_char_valid;
    assign o_trim_overflow = r_trim_overflow;
    assign o_name_done     = r_name_done;
    assign o_last_of_run   = r_last_of_run;

endmodule

`default_nettype wire

// ===== hdl/dn_normalize_stream.sv =====
// Streaming normalizer for a distinguished name. One byte of the name enters
// per input word, with i_final_byte set on its last byte, and the normalized
// name leaves one byte per output word. A parser in the front end takes one
// input word per cycle while the queue has room and turns it into a command;
// a four-entry command queue decouples it from the output sequencer, which
// emits one word per cycle unless i_out_stall holds it. Plain text, in which
// each byte yields one output, thus streams at one byte per cycle. Each
// additional output of the same input (a blank pushed out of a full blank
// store, the blanks released when a value continues, an escaped backslash or
// quote pair, the blanks and held backslash at the end of a name) takes an
// output word of its own; the queue absorbs short bursts, so the input stalls
// only while all four queue entries are taken. An input word that produces
// nothing (a dropped blank, a held backslash) still takes one queue slot.
// Every result of one input word carries o_last_of_run on its final word,
// and the final word of a name carries o_name_done; a name end that yields
// no byte gives one word with o_char_valid low and o_out_char zero. The
// blank store holds up to MAX_PENDING_BLANKS blanks of an unquoted value.
`default_nettype none

module dn_normalize_stream
    import dnn_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,

    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_char,
    input  wire logic       i_final_byte,

    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_char,
    output logic            o_char_valid,
    output logic            o_trim_overflow,
    output logic            o_name_done,
    output logic            o_last_of_run
);

    // Commands travel from the parser to the sequencer through the queue.
    t_cmd wr_cmd;
    t_cmd rd_cmd;
    logic wr_en;
    logic rd_en;
    logic q_full;
    logic q_empty;

    // The parser accepts a word whenever the queue has room.
    dnn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_char  (i_in_char),
        .i_final (i_final_byte),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_wr_en (wr_en),
        .o_cmd   (wr_cmd)
    );

    dnn_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_cmd (wr_cmd),
        .o_full   (q_full),
        .i_rd_en  (rd_en),
        .o_rd_cmd (rd_cmd),
        .o_empty  (q_empty)
    );

    // The sequencer owns the blank store and the registered output stage.
    dnn_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (q_empty),
        .i_cmd           (rd_cmd),
        .o_rd_en         (rd_en),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_char      (o_out_char),
        .o_char_valid    (o_char_valid),
        .o_trim_overflow (o_trim_overflow),
        .o_name_done     (o_name_done),
        .o_last_of_run   (o_last_of_run)
    );

endmodule

`default_nettype wire
